### hw/rtl/lir_pkg.sv
// ----------------------------------------------------------------------------
// lir_pkg
// Shared types and constants of the linear interpolation resampler: sample
// and product widths, register indexes and the issue record between the
// run controller and the lane pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package lir_pkg;

	// fixed field widths
	localparam int SAMPLE_W = 16;
	localparam int VOL_W    = 16;
	localparam int OUT_W    = 32;
	localparam int INC_W    = 32;
	// phase sum: fraction plus a 32-bit increment never exceeds 33 bits
	localparam int SUM_W    = INC_W + 1;
	localparam int REG_IDX_W = 2;
	localparam int DATA_W   = 32;

	localparam logic [INC_W-1:0] PHASE_INC_RESET = 32'h4000_0000;

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic signed [VOL_W-1:0]    volume_t;
	typedef logic signed [OUT_W-1:0]    product_t;

	// configuration register indexes
	typedef enum logic [REG_IDX_W-1:0] {
		REG_PHASE_INC = 2'd0,
		REG_LEFT_VOL  = 2'd1,
		REG_RIGHT_VOL = 2'd2,
		REG_STEREO    = 2'd3
	} reg_idx_t;

	// run controller states
	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_RUN  = 2'b10
	} state_t;

	// one output slot handed to the lanes
	typedef struct packed {
		logic valid;
		logic last;
	} issue_t;

endpackage

`default_nettype wire

### hw/rtl/lir_frame_if.sv
// ----------------------------------------------------------------------------
// lir_frame_if
// Input channel: one stereo frame per request.
// ----------------------------------------------------------------------------
`default_nettype none

interface lir_frame_if;
	logic             valid;
	logic             ready;
	lir_pkg::sample_t left_sample;
	lir_pkg::sample_t right_sample;

	modport source (output valid, output left_sample, output right_sample, input ready);
	modport sink   (input valid, input left_sample, input right_sample, output ready);
endinterface

`default_nettype wire

### hw/rtl/lir_result_if.sv
// ----------------------------------------------------------------------------
// lir_result_if
// Output channel: one scaled stereo output sample per request.
// ----------------------------------------------------------------------------
`default_nettype none

interface lir_result_if;
	logic              valid;
	logic              ready;
	lir_pkg::product_t left_out;
	lir_pkg::product_t right_out;
	logic              last_of_run;

	modport source (output valid, output left_out, output right_out, output last_of_run,
		input ready);
	modport sink   (input valid, input left_out, input right_out, input last_of_run,
		output ready);
endinterface

`default_nettype wire

### hw/rtl/lir_lane.sv
// ----------------------------------------------------------------------------
// lir_lane
// One channel of the interpolator: difference times weight, floor shift and
// add to the previous sample, then volume gain. Three stages, all moving on
// the common advance strobe.
// ----------------------------------------------------------------------------
`default_nettype none

module lir_lane #(
	parameter int INTERP_BITS = 15
) (
	input  wire  logic                         clk,
	input  wire  logic                         adv,
	input  wire  lir_pkg::sample_t             prev,
	input  wire  lir_pkg::sample_t             cur,
	input  wire  logic [INTERP_BITS-1:0]       weight,
	input  wire  lir_pkg::volume_t             vol,
	output       lir_pkg::product_t            prod
);

	localparam int DIFF_W = lir_pkg::SAMPLE_W + 1;
	localparam int PROD_W = DIFF_W + INTERP_BITS + 1;

	logic signed [DIFF_W-1:0]      diff;
	logic signed [INTERP_BITS:0]   wgt;
	logic signed [PROD_W-1:0]      dprod_s1;
	lir_pkg::sample_t              prev_s1;
	logic signed [PROD_W-1:0]      shifted;
	lir_pkg::sample_t              samp_s2;
	lir_pkg::product_t             gain_s3;

	// weighted difference
	assign diff = DIFF_W'(cur) - DIFF_W'(prev);
	assign wgt  = $signed({1'b0, weight});

	always_ff @(posedge clk) begin
		if (adv) begin
			dprod_s1 <= PROD_W'(diff) * PROD_W'(wgt);
			prev_s1  <= prev;
		end
	end

	// floor shift; the sum stays between prev and cur so 16 bits suffice
	assign shifted = dprod_s1 >>> INTERP_BITS;

	always_ff @(posedge clk) begin
		if (adv) begin
			samp_s2 <= prev_s1 + $signed(shifted[lir_pkg::SAMPLE_W-1:0]);
		end
	end

	// volume gain
	always_ff @(posedge clk) begin
		if (adv) begin
			gain_s3 <= lir_pkg::OUT_W'(vol) * lir_pkg::OUT_W'(samp_s2);
		end
	end

	assign prod = gain_s3;

endmodule

`default_nettype wire

### hw/rtl/lir_ctrl.sv
// ----------------------------------------------------------------------------
// lir_ctrl
// Run controller: takes frames, counts down skipped frames, steps the phase
// accumulator once per output slot and holds the previous and current frame
// that feed the lanes.
// ----------------------------------------------------------------------------
`default_nettype none

module lir_ctrl #(
	parameter int PHASE_BITS  = 30,
	parameter int INTERP_BITS = 15,
	parameter int MAX_RUN     = 64
) (
	input  wire  logic                          clk,
	input  wire  logic                          arst_n,
	lir_frame_if.sink                           frame,
	input  wire  logic                          adv,
	input  wire  logic [lir_pkg::INC_W-1:0]     phase_inc,
	input  wire  logic                          stereo,
	output       lir_pkg::issue_t               issue,
	output       lir_pkg::sample_t              left_prev,
	output       lir_pkg::sample_t              left_cur,
	output       lir_pkg::sample_t              right_prev,
	output       lir_pkg::sample_t              right_cur,
	output       logic [INTERP_BITS-1:0]        weight
);

	localparam int CNT_W = (MAX_RUN > 1) ? $clog2(MAX_RUN) : 1;
	localparam int SUM_W = lir_pkg::SUM_W;

	lir_pkg::state_t          state_q;
	logic [PHASE_BITS-1:0]    frac_q;
	logic [1:0]               skip_q;
	logic [CNT_W-1:0]         cnt_q;
	lir_pkg::sample_t         prev_l_q;
	lir_pkg::sample_t         prev_r_q;
	lir_pkg::sample_t         cur_l_q;
	lir_pkg::sample_t         cur_r_q;

	logic                     accept;
	logic                     step;
	logic [SUM_W-1:0]         sum;
	logic [SUM_W-1:0]         carry;
	logic                     carry_nz;
	logic                     run_end;
	logic [1:0]               skip_new;

	assign frame.ready = (state_q == lir_pkg::ST_IDLE);
	assign accept      = frame.valid && frame.ready;
	assign step        = (state_q == lir_pkg::ST_RUN) && adv;

	// phase accumulator and end of run
	assign sum      = SUM_W'(frac_q) + SUM_W'(phase_inc);
	assign carry    = sum >> PHASE_BITS;
	assign carry_nz = (carry != '0);
	assign run_end  = carry_nz || (cnt_q == CNT_W'(MAX_RUN - 1));
	assign skip_new = !carry_nz ? 2'd0 :
		(carry >= SUM_W'(4)) ? 2'd3 : 2'(carry - SUM_W'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= lir_pkg::ST_IDLE;
			frac_q   <= '0;
			skip_q   <= 2'd0;
			cnt_q    <= '0;
			prev_l_q <= '0;
			prev_r_q <= '0;
		end else begin
			unique case (state_q)
				lir_pkg::ST_IDLE: begin
					if (accept) begin
						if (skip_q != 2'd0) begin
							skip_q   <= skip_q - 2'd1;
							prev_l_q <= frame.left_sample;
							if (stereo) begin
								prev_r_q <= frame.right_sample;
							end
						end else begin
							state_q <= lir_pkg::ST_RUN;
							cnt_q   <= '0;
						end
					end
				end
				lir_pkg::ST_RUN: begin
					if (adv) begin
						frac_q <= sum[PHASE_BITS-1:0];
						cnt_q  <= cnt_q + CNT_W'(1);
						if (run_end) begin
							state_q  <= lir_pkg::ST_IDLE;
							skip_q   <= skip_new;
							prev_l_q <= cur_l_q;
							if (stereo) begin
								prev_r_q <= cur_r_q;
							end
						end
					end
				end
				default: begin
					state_q <= lir_pkg::ST_IDLE;
				end
			endcase
		end
	end

	// current frame, held for the whole run
	always_ff @(posedge clk) begin
		if (accept) begin
			cur_l_q <= frame.left_sample;
			cur_r_q <= frame.right_sample;
		end
	end

	// lane feed; mono sends the left channel to both lanes
	assign issue.valid = step;
	assign issue.last  = run_end;
	assign left_prev   = prev_l_q;
	assign left_cur    = cur_l_q;
	assign right_prev  = stereo ? prev_r_q : prev_l_q;
	assign right_cur   = stereo ? cur_r_q : cur_l_q;
	assign weight      = frac_q[PHASE_BITS-1 -: INTERP_BITS];

	// skipped frame only counts down
	a_skip_countdown: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && skip_q != 2'd0) |=>
		(state_q == lir_pkg::ST_IDLE && skip_q == $past(skip_q) - 2'd1))
		else $error("skipped frame did not count down");

	// no frames pending skip while a run is going
	a_run_no_skip: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == lir_pkg::ST_RUN) |-> (skip_q == 2'd0))
		else $error("run started with skip pending");

	// end of run hands the current frame over as previous
	a_run_end: assert property (@(posedge clk) disable iff (!arst_n)
		(step && run_end) |=> (state_q == lir_pkg::ST_IDLE && prev_l_q == $past(cur_l_q)))
		else $error("run end did not update previous frame");

	// a stall freezes the phase and slot count
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == lir_pkg::ST_RUN && !adv) |=>
		(state_q == lir_pkg::ST_RUN && $stable(frac_q) && $stable(cnt_q)))
		else $error("phase moved while stalled");

endmodule

`default_nettype wire

### hw/rtl/linear_interp_audio_resampler.sv
// ----------------------------------------------------------------------------
// linear_interp_audio_resampler
// Linear interpolation sample-rate converter for 16-bit stereo or mono audio.
// ----------------------------------------------------------------------------
// Usage:
//  - frame channel carries one input frame per request; result channel
//    carries one gain-scaled output sample pair per request, last_of_run set
//    on the final output caused by a frame.
//  - registers (phase increment, left/right volume, stereo mode) are written
//    through wr_en/wr_index/wr_data while no frame is in flight (user rule).
//  - a frame that starts a run of k outputs occupies the controller for its
//    accept, then one phase step per output (k up to MAX_RUN); a skipped
//    frame only takes its accept. The phase accumulator steps once per cycle
//    unless the result channel stalls.
//  - after a frame is accepted, the first output slot of its run issues from
//    the run state and passes the lane stages (multiply, add, volume
//    multiply); the last stage acts as the output register.
//  - a stall on the result channel freezes the phase accumulator and all
//    lane stages; the next frame is taken as soon as the current run has
//    issued its last output slot.
//  - reset clears previous frame, phase and skip count, and loads the
//    register reset values (increment one, volumes zero, mono).
// ----------------------------------------------------------------------------
`default_nettype none

module linear_interp_audio_resampler #(
	parameter int PHASE_BITS  = 30,
	parameter int INTERP_BITS = 15,
	parameter int MAX_RUN     = 64
) (
	input  wire  logic                             clk,
	input  wire  logic                             arst_n,
	lir_frame_if.sink                              frame,
	lir_result_if.source                           result,
	input  wire  logic                             wr_en,
	input  wire  logic [lir_pkg::REG_IDX_W-1:0]    wr_index,
	input  wire  logic [lir_pkg::DATA_W-1:0]       wr_data
);

	logic [lir_pkg::INC_W-1:0]  phase_inc_q;
	lir_pkg::volume_t           left_vol_q;
	lir_pkg::volume_t           right_vol_q;
	logic                       stereo_q;

	logic                       adv;
	lir_pkg::issue_t            issue;
	lir_pkg::sample_t           left_prev;
	lir_pkg::sample_t           left_cur;
	lir_pkg::sample_t           right_prev;
	lir_pkg::sample_t           right_cur;
	logic [INTERP_BITS-1:0]     weight;
	lir_pkg::product_t          left_prod;
	lir_pkg::product_t          right_prod;

	lir_pkg::issue_t            slot_s1;
	lir_pkg::issue_t            slot_s2;
	lir_pkg::issue_t            slot_s3;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_inc_q <= lir_pkg::PHASE_INC_RESET;
			left_vol_q  <= '0;
			right_vol_q <= '0;
			stereo_q    <= 1'b0;
		end else if (wr_en) begin
			unique case (lir_pkg::reg_idx_t'(wr_index))
				lir_pkg::REG_PHASE_INC: phase_inc_q <= wr_data[lir_pkg::INC_W-1:0];
				lir_pkg::REG_LEFT_VOL:  left_vol_q  <= wr_data[lir_pkg::VOL_W-1:0];
				lir_pkg::REG_RIGHT_VOL: right_vol_q <= wr_data[lir_pkg::VOL_W-1:0];
				lir_pkg::REG_STEREO:    stereo_q    <= wr_data[0];
				default: ;
			endcase
		end
	end

	// whole pipeline moves unless the output stage is held
	assign adv = !slot_s3.valid || result.ready;

	lir_ctrl #(
		.PHASE_BITS  (PHASE_BITS),
		.INTERP_BITS (INTERP_BITS),
		.MAX_RUN     (MAX_RUN)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.frame      (frame),
		.adv        (adv),
		.phase_inc  (phase_inc_q),
		.stereo     (stereo_q),
		.issue      (issue),
		.left_prev  (left_prev),
		.left_cur   (left_cur),
		.right_prev (right_prev),
		.right_cur  (right_cur),
		.weight     (weight)
	);

	lir_lane #(
		.INTERP_BITS (INTERP_BITS)
	) u_lane_left (
		.clk    (clk),
		.adv    (adv),
		.prev   (left_prev),
		.cur    (left_cur),
		.weight (weight),
		.vol    (left_vol_q),
		.prod   (left_prod)
	);

	lir_lane #(
		.INTERP_BITS (INTERP_BITS)
	) u_lane_right (
		.clk    (clk),
		.adv    (adv),
		.prev   (right_prev),
		.cur    (right_cur),
		.weight (weight),
		.vol    (right_vol_q),
		.prod   (right_prod)
	);

	// slot tracking alongside the lane stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_s1 <= '0;
			slot_s2 <= '0;
			slot_s3 <= '0;
		end else if (adv) begin
			slot_s1 <= issue;
			slot_s2 <= slot_s1;
			slot_s3 <= slot_s2;
		end
	end

	// merge the two lanes into one result
	assign result.valid       = slot_s3.valid;
	assign result.left_out    = left_prod;
	assign result.right_out   = right_prod;
	assign result.last_of_run = slot_s3.last;

endmodule

`default_nettype wire

### test/lir_tb_pkg.sv
// ----------------------------------------------------------------------------
// lir_tb_pkg
// Output predictor and checker for the linear interpolation resampler bench:
// tracks the register settings, previous frame, phase fraction and skip
// count, expands each accepted frame into its expected output requests and
// compares the outputs against them in order.
// ----------------------------------------------------------------------------
package lir_tb_pkg;

	import lir_pkg::*;

	localparam int PHASE_FRAC_W = 30;
	// phase fraction bits dropped to form the interpolation weight
	localparam int WEIGHT_SHIFT = 15;
	localparam int INTERP_SHIFT = 15;
	localparam int RUN_CAP      = 64;

	typedef struct packed {
		product_t left_out;
		product_t right_out;
		logic     last_of_run;
	} out_pair_t;

	class resample_checker;
		logic [INC_W-1:0]        phase_inc;
		volume_t                 left_vol;
		volume_t                 right_vol;
		logic                    stereo;
		sample_t                 prev_left;
		sample_t                 prev_right;
		logic [PHASE_FRAC_W-1:0] phase;
		logic [1:0]              skip_left;
		out_pair_t               pending[$];
		int unsigned             errors;

		function new();
			phase_inc  = PHASE_INC_RESET;
			left_vol   = '0;
			right_vol  = '0;
			stereo     = 1'b0;
			prev_left  = '0;
			prev_right = '0;
			phase      = '0;
			skip_left  = '0;
			errors     = 0;
		endfunction

		// mirror of a register write
		function void write_reg(reg_idx_t idx, logic [DATA_W-1:0] data);
			case (idx)
				REG_PHASE_INC: phase_inc = data;
				REG_LEFT_VOL:  left_vol  = volume_t'(data[VOL_W-1:0]);
				REG_RIGHT_VOL: right_vol = volume_t'(data[VOL_W-1:0]);
				REG_STEREO:    stereo    = data[0];
				default: ;
			endcase
		endfunction

		// point between a and b at the current phase, rounded towards minus infinity
		function sample_t interp(sample_t a, sample_t b);
			longint diff;
			longint weight;
			longint prod;
			diff   = longint'(b) - longint'(a);
			weight = longint'(phase >> WEIGHT_SHIFT);
			prod   = diff * weight;
			return sample_t'(longint'(a) + (prod >>> INTERP_SHIFT));
		endfunction

		// expand one accepted frame into its run of outputs
		function void note_frame(sample_t cur_left, sample_t cur_right);
			sample_t          s_left;
			sample_t          s_right;
			logic [SUM_W-1:0] sum;
			logic [2:0]       carry;
			out_pair_t        o;
			if (skip_left != 2'd0) begin
				skip_left = skip_left - 2'd1;
			end else begin
				for (int n = 0; n < RUN_CAP; n++) begin
					s_left  = interp(prev_left, cur_left);
					s_right = stereo ? interp(prev_right, cur_right) : s_left;
					sum     = {3'b000, phase} + {1'b0, phase_inc};
					carry   = sum[SUM_W-1:PHASE_FRAC_W];
					phase   = sum[PHASE_FRAC_W-1:0];
					o.left_out    = product_t'(longint'(left_vol) * longint'(s_left));
					o.right_out   = product_t'(longint'(right_vol) * longint'(s_right));
					o.last_of_run = (carry != 3'd0) || (n == RUN_CAP - 1);
					pending.push_back(o);
					if (carry != 3'd0) begin
						// skip count saturates at three
						skip_left = (carry > 3'd4) ? 2'd3 : 2'(carry - 3'd1);
						break;
					end
				end
			end
			prev_left = cur_left;
			if (stereo) prev_right = cur_right;
		endfunction

		function void report(string field, longint want, longint got, realtime stamp);
			errors++;
			$display("%0.3f ns: %s mismatch, expected %0d, got %0d", stamp, field, want,
				got);
		endfunction

		// compare one accepted output request with the oldest expectation
		function void check_output(product_t lo, product_t ro, logic last, realtime stamp);
			out_pair_t want;
			if (pending.size() == 0) begin
				errors++;
				$display("%0.3f ns: unexpected output, expected none, got %0d/%0d/%0b",
					stamp, lo, ro, last);
				return;
			end
			want = pending.pop_front();
			if (want.left_out !== lo) report("left_out", want.left_out, lo, stamp);
			if (want.right_out !== ro) report("right_out", want.right_out, ro, stamp);
			if (want.last_of_run !== last)
				report("last_of_run", want.last_of_run, last, stamp);
		endfunction
	endclass

endpackage

### test/linear_interp_audio_resampler_tb.sv
// ----------------------------------------------------------------------------
// linear_interp_audio_resampler_tb
// Self-checking bench for the resampler: a directed pass over the sample and
// gain extremes, skipped frames, the run cap, large carries and mode changes,
// then randomised register settings and frames with random idling on both
// channels. Every output request is checked against the predicted run.
// ----------------------------------------------------------------------------
module linear_interp_audio_resampler_tb;

	timeunit 1ns;
	timeprecision 1ps;

	import lir_pkg::*;
	import lir_tb_pkg::*;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int SETTLE_CYCLES  = 12;
	localparam int RANDOM_PHASES  = 8;
	localparam int PHASE_FRAMES   = 19;

	logic                 clk        = 1'b0;
	logic                 arst_n     = 1'b0;
	logic                 sink_ready = 1'b0;
	logic                 wr_en      = 1'b0;
	logic [REG_IDX_W-1:0] wr_index   = '0;
	logic [DATA_W-1:0]    wr_data    = '0;
	logic                 calm       = 1'b0;
	int                   stall_left = 0;
	int                   idle_cycles = 0;

	resample_checker chk = new();

	lir_frame_if  frame_ch();
	lir_result_if result_ch();

	assign result_ch.ready = sink_ready;

	linear_interp_audio_resampler dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.frame    (frame_ch),
		.result   (result_ch),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data)
	);

	always #4 clk = ~clk;

	// output back-pressure: mostly short stalls, now and then a long one
	always @(posedge clk) begin
		if (stall_left != 0) begin
			sink_ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (!calm && $urandom_range(0, 99) < 20) begin
			sink_ready <= 1'b0;
			stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
				: $urandom_range(0, 2);
		end else begin
			sink_ready <= 1'b1;
		end
	end

	// request monitor, output check and watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if (frame_ch.valid && frame_ch.ready)
				chk.note_frame(frame_ch.left_sample, frame_ch.right_sample);
			if (result_ch.valid && sink_ready)
				chk.check_output(result_ch.left_out, result_ch.right_out,
					result_ch.last_of_run, $realtime);
			if ((frame_ch.valid && frame_ch.ready) || (result_ch.valid && sink_ready) || wr_en)
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

	function automatic sample_t pick_sample();
		logic [1:0] sel;
		sel = 2'($urandom_range(0, 3));
		if ($urandom_range(0, 5) != 0) return sample_t'($urandom);
		case (sel)
			2'd0: return sample_t'(16'h8000);
			2'd1: return sample_t'(16'h7FFF);
			2'd2: return sample_t'(16'h0000);
			default: return sample_t'(16'hFFFF);
		endcase
	endfunction

	// one frame request, followed by a random gap
	task automatic send_frame(sample_t l, sample_t r);
		int gap;
		frame_ch.valid        <= 1'b1;
		frame_ch.left_sample  <= l;
		frame_ch.right_sample <= r;
		do @(posedge clk); while (frame_ch.ready !== 1'b1);
		if (calm) gap = 0;
		else if ($urandom_range(0, 99) < 60) gap = 0;
		else if ($urandom_range(0, 9) != 0) gap = $urandom_range(1, 3);
		else gap = $urandom_range(10, 40);
		if (gap != 0) begin
			frame_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// all four registers, one write per cycle
	task automatic set_config(logic [INC_W-1:0] inc, volume_t vl, volume_t vr, logic st);
		reg_idx_t          idx [4];
		logic [DATA_W-1:0] val [4];
		idx = '{REG_PHASE_INC, REG_LEFT_VOL, REG_RIGHT_VOL, REG_STEREO};
		val = '{inc, DATA_W'(signed'(vl)), DATA_W'(signed'(vr)), DATA_W'(st)};
		for (int i = 0; i < 4; i++) begin
			wr_en    <= 1'b1;
			wr_index <= idx[i];
			wr_data  <= val[i];
			@(posedge clk);
			chk.write_reg(idx[i], val[i]);
		end
		wr_en <= 1'b0;
	endtask

	// drain: no frame offered, every output in, skipped frames settled
	task automatic wait_idle();
		frame_ch.valid <= 1'b0;
		@(posedge clk);
		while (chk.pending.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin
		logic [INC_W-1:0] inc;
		volume_t          vl;
		volume_t          vr;
		frame_ch.valid        = 1'b0;
		frame_ch.left_sample  = '0;
		frame_ch.right_sample = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: unit increment, zero gains
		send_frame(16'sh1234, -16'sh0042);
		send_frame(-16'sh7000, 16'sh7000);
		wait_idle();

		// two outputs per frame, full-scale samples and gains
		set_config(32'h2000_0000, 16'sh7FFF, 16'sh8000, 1'b1);
		send_frame(16'sh7FFF, 16'sh8000);
		send_frame(16'sh8000, 16'sh7FFF);
		send_frame(16'sh0000, 16'sh0000);
		send_frame(-16'sd1, 16'sd1);
		send_frame(16'sh7FFF, 16'sh7FFF);
		wait_idle();

		// largest increment: big carries, saturated skip count
		set_config(32'hFFFF_FFFF, 16'sh8000, 16'sh8000, 1'b0);
		for (int i = 0; i < 5; i++) send_frame(pick_sample(), pick_sample());
		wait_idle();

		// zero increment: run stops at the cap
		set_config(32'h0000_0000, 16'sd1, -16'sd1, 1'b1);
		send_frame(16'sh8000, 16'sh7FFF);
		send_frame(16'sh7FFF, 16'sh8000);
		wait_idle();

		// slowest legal increment: 64 outputs a frame
		set_config(32'h0100_0000, 16'sh7FFF, 16'sh7FFF, 1'b1);
		send_frame(16'sh4000, -16'sh4000);
		send_frame(-16'sh4000, 16'sh4000);
		wait_idle();

		// mono keeps the old previous right sample, then back to stereo
		set_config(32'h6000_0000, 16'sh8000, 16'sd12345, 1'b0);
		for (int i = 0; i < 3; i++) send_frame(pick_sample(), pick_sample());
		wait_idle();
		set_config(32'h6000_0000, 16'sh8000, 16'sd12345, 1'b1);
		for (int i = 0; i < 3; i++) send_frame(pick_sample(), pick_sample());
		wait_idle();

		// random settings and frames
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			case ($urandom_range(0, 9))
				0: inc = 32'h0100_0000;
				1: inc = 32'hFFFF_FFFF;
				2: inc = $urandom_range(0, 32'h00FF_FFFF);
				default: inc = $urandom_range(32'h0800_0000, 32'hFFFF_FFFF);
			endcase
			vl = pick_sample();
			vr = pick_sample();
			set_config(inc, vl, vr, 1'($urandom_range(0, 1)));
			calm = ($urandom_range(0, 3) == 0);
			for (int i = 0; i < PHASE_FRAMES; i++) send_frame(pick_sample(), pick_sample());
			wait_idle();
		end

		if (chk.errors == 0 && chk.pending.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

### files.f
hw/rtl/lir_pkg.sv
hw/rtl/lir_frame_if.sv
hw/rtl/lir_result_if.sv
hw/rtl/lir_lane.sv
hw/rtl/lir_ctrl.sv
hw/rtl/linear_interp_audio_resampler.sv
test/lir_tb_pkg.sv
test/linear_interp_audio_resampler_tb.sv
